>>> hdl/mrc_pkg.sv
// Shared constants, codes and types of the mixed-radix index counter.
package mrc_pkg;

    // Fixed field widths
    localparam int FLAT_W    = 48;
    localparam int CMD_W     = 3;
    localparam int SEL_W     = 3;
    localparam int NUM_W     = 3;
    localparam int REG_IDX_W = 3;
    localparam int CNT_W     = 4;
    localparam int OUT_IDX   = 6;
    localparam int NUM_SIZE_REGS = 6;

    // Parameter defaults
    localparam int DEF_MAX_DIMS   = 6;
    localparam int DEF_SIZE_WIDTH = 8;

    // Divider: quotient bits retired per cycle
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = FLAT_W / DIGIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_STEP_ALL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_INDEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEP_ONE  = 3'd4;

    // Register indexes
    localparam int REG_NUM_DIMS  = 0;
    localparam int REG_SIZE_DIM0 = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_CHECK,
        S_MUL_OLD,
        S_MUL_NEW,
        S_DIV_WAIT,
        S_UPDATE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hdl/mrc_divider.sv
// Digit-serial divider: flat word by one extent, several quotient bits per cycle.
module mrc_divider #(
    parameter int SIZE_WIDTH = mrc_pkg::DEF_SIZE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mrc_pkg::FLAT_W-1:0]  dividend,
    input  logic [SIZE_WIDTH-1:0]       divisor,
    output mrc_pkg::div_stat_t          stat,
    output logic [mrc_pkg::FLAT_W-1:0]  quotient,
    output logic [SIZE_WIDTH-1:0]       remainder
);

    localparam int FW = mrc_pkg::FLAT_W;
    localparam int DW = mrc_pkg::DIGIT_W;
    localparam int CW = mrc_pkg::DIV_CNT_W;

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [FW-1:0]       work_reg;
    logic [SIZE_WIDTH-1:0] rem_reg;
    logic [SIZE_WIDTH-1:0] dvsr_reg;

    logic [SIZE_WIDTH-1:0] rem_next;
    logic [DW-1:0]       digit_q;
    logic [SIZE_WIDTH:0] trial;

    // One digit of restoring division: shift in a bit, subtract when it fits
    always_comb
    begin
        rem_next = rem_reg;
        digit_q  = '0;
        trial    = '0;
        for (int i = 0; i < DW; i++)
        begin
            trial = {rem_next, work_reg[FW-1-i]};
            if (trial >= {1'b0, dvsr_reg})
            begin
                trial             = trial - {1'b0, dvsr_reg};
                digit_q[DW-1-i]   = 1'b1;
            end
            rem_next = trial[SIZE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(mrc_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[FW-DW-1:0], digit_q};
            rem_reg  <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/mixed_radix_index_counter.sv
// Top level of the mixed-radix index counter: command sequencer and state.
//
// Keeps a multi-dimensional index (dimension zero least significant) and its
// flat position. Each input item carries a command: step all with carry,
// clear, load a flat position, set one index, or step one index. Each item
// gives exactly one result item with the flat position, all indices and
// the range_error / wrapped flags.
// Channels: valid/stall on both sides; an item moves when valid is high
// and stall is low. in_stall is high while an item is in work.
// Step all, clear and unused codes pass the update step, then the
// finish step. Step one and set one first build the stride with the
// shared multiplier, one dimension a cycle. Load builds the total the
// same way and then runs the digit divider once per dimension in use.
// One item is in work at a time; the multiplier is 48-bit by extent.
// The result sits in an output register, so a stalled receiver only holds
// the sequencer at its final step. Reset gives one dimension of extent 1,
// all indices and the flat position zero. A write to a configuration register
// (taken only while idle) clears the indices and the flat position.
module mixed_radix_index_counter #(
    parameter int MAX_DIMS   = mrc_pkg::DEF_MAX_DIMS,
    parameter int SIZE_WIDTH = mrc_pkg::DEF_SIZE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [mrc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [((SIZE_WIDTH > mrc_pkg::NUM_W) ? SIZE_WIDTH : mrc_pkg::NUM_W)-1:0] cfg_wdata,
    // input items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mrc_pkg::CMD_W-1:0]        cmd,
    input  logic [mrc_pkg::FLAT_W-1:0]       flat_value,
    input  logic [mrc_pkg::SEL_W-1:0]        dim_select,
    input  logic [SIZE_WIDTH-1:0]            index_value,
    // result items
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mrc_pkg::FLAT_W-1:0]       flat_pos,
    output logic [SIZE_WIDTH-1:0]            idx0,
    output logic [SIZE_WIDTH-1:0]            idx1,
    output logic [SIZE_WIDTH-1:0]            idx2,
    output logic [SIZE_WIDTH-1:0]            idx3,
    output logic [SIZE_WIDTH-1:0]            idx4,
    output logic [SIZE_WIDTH-1:0]            idx5,
    output logic                             range_error,
    output logic                             wrapped
);

    localparam int FW = mrc_pkg::FLAT_W;
    localparam int SW = SIZE_WIDTH;
    localparam int CW = mrc_pkg::CNT_W;
    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NO = mrc_pkg::OUT_IDX;

    // Architectural state
    mrc_pkg::state_t state_reg, state_next;
    logic [mrc_pkg::NUM_W-1:0] num_dims_reg, num_dims_next;
    logic [SW-1:0] size_reg [MAX_DIMS];
    logic [SW-1:0] size_next [MAX_DIMS];
    logic [SW-1:0] idx_reg [MAX_DIMS];
    logic [SW-1:0] idx_next [MAX_DIMS];
    logic [FW-1:0] flat_reg, flat_next;
    logic          out_valid_reg, out_valid_next;

    // Item and work registers
    logic [mrc_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [FW-1:0] fv_reg, fv_next;
    logic [mrc_pkg::SEL_W-1:0] sel_reg, sel_next;
    logic [SW-1:0] val_reg, val_next;
    logic [FW-1:0] prod_reg, prod_next;
    logic [FW-1:0] acc_reg, acc_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic          err_reg, err_next;
    logic          wrap_reg, wrap_next;

    // Output registers
    logic [FW-1:0] out_flat_reg, out_flat_next;
    logic [SW-1:0] out_idx_reg [NO];
    logic [SW-1:0] out_idx_next [NO];
    logic          out_err_reg, out_err_next;
    logic          out_wrap_reg, out_wrap_next;

    // Derived values
    logic [SW-1:0] ext [MAX_DIMS];
    logic [CW-1:0] n_dims;
    logic [CW-1:0] k_inc;
    logic [IW-1:0] sel_i;
    logic [IW-1:0] k_i;
    logic          sel_ok;
    logic          sel_in_ok;
    logic [SW-1:0] idx_sel;
    logic [SW-1:0] ext_sel;
    logic [SW-1:0] ext_k;
    logic [SW-1:0] mul_b;
    logic [FW+SW-1:0] mul_full;
    logic [FW-1:0] mul_lo;
    logic [SW-1:0] step_idx [MAX_DIMS];
    logic          step_carry;
    logic [SW:0]   step_inc;
    logic          idx_ok;
    logic          cfg_hit;

    // Divider interface
    logic               div_start;
    logic [FW-1:0]      div_dividend;
    logic [SW-1:0]      div_divisor;
    mrc_pkg::div_stat_t div_stat;
    logic [FW-1:0]      div_quo;
    logic [SW-1:0]      div_rem;

    mrc_divider #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Extents: a zero size register counts as one
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            ext[d] = (size_reg[d] == '0) ? SW'(1) : size_reg[d];
        end
    end

    // Dimensions in use: zero acts as one, clamp at MAX_DIMS
    always_comb
    begin
        if (num_dims_reg == '0)
            n_dims = CW'(1);
        else if (CW'(num_dims_reg) > CW'(MAX_DIMS))
            n_dims = CW'(MAX_DIMS);
        else
            n_dims = CW'(num_dims_reg);
    end

    assign k_inc     = k_reg + 1'b1;
    assign k_i       = k_reg[IW-1:0];
    assign sel_i     = sel_reg[IW-1:0];
    assign sel_ok    = CW'(sel_reg) < n_dims;
    assign sel_in_ok = CW'(dim_select) < n_dims;
    assign idx_sel   = idx_reg[sel_i];
    assign ext_sel   = ext[sel_i];
    assign ext_k     = ext[k_i];

    // Shared multiplier: stride build and stride times index
    always_comb
    begin
        unique case (state_reg)
            mrc_pkg::S_MUL_OLD: mul_b = idx_sel;
            mrc_pkg::S_MUL_NEW: mul_b = val_reg;
            default:            mul_b = ext_k;
        endcase
    end

    assign mul_full = prod_reg * mul_b;
    assign mul_lo   = mul_full[FW-1:0];

    // Full step: ripple the carry up through the dimensions in use
    always_comb
    begin
        step_carry = 1'b1;
        step_inc   = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            step_idx[d] = idx_reg[d];
            if ((CW'(d) < n_dims) && step_carry)
            begin
                step_inc = {1'b0, idx_reg[d]} + 1'b1;
                if (step_inc >= {1'b0, ext[d]})
                begin
                    step_idx[d] = '0;
                end
                else
                begin
                    step_idx[d] = step_inc[SW-1:0];
                    step_carry  = 1'b0;
                end
            end
        end
    end

    // Every stored index below its extent
    always_comb
    begin
        idx_ok = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (idx_reg[d] >= ext[d])
                idx_ok = 1'b0;
        end
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        num_dims_next  = num_dims_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        flat_next      = flat_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd_next       = cmd_reg;
        fv_next        = fv_reg;
        sel_next       = sel_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        limit_next     = limit_reg;
        err_next       = err_reg;
        wrap_next      = wrap_reg;
        out_flat_next  = out_flat_reg;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;
        out_wrap_next  = out_wrap_reg;
        div_start      = 1'b0;
        div_dividend   = div_quo;
        div_divisor    = ext[k_inc[IW-1:0]];
        cfg_hit        = 1'b0;

        unique case (state_reg)
            mrc_pkg::S_IDLE:
            begin
                // Register writes: any hit clears the counter
                if (cfg_we)
                begin
                    if (cfg_index == mrc_pkg::REG_IDX_W'(mrc_pkg::REG_NUM_DIMS))
                    begin
                        num_dims_next = cfg_wdata[mrc_pkg::NUM_W-1:0];
                        cfg_hit       = 1'b1;
                    end
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        if ((d < mrc_pkg::NUM_SIZE_REGS) &&
                            (cfg_index == mrc_pkg::REG_IDX_W'(mrc_pkg::REG_SIZE_DIM0 + d)))
                        begin
                            size_next[d] = cfg_wdata[SW-1:0];
                            cfg_hit      = 1'b1;
                        end
                    end
                    if (cfg_hit)
                    begin
                        for (int d = 0; d < MAX_DIMS; d++)
                            idx_next[d] = '0;
                        flat_next = '0;
                    end
                end
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    fv_next    = flat_value;
                    sel_next   = dim_select;
                    val_next   = index_value;
                    err_next   = 1'b0;
                    wrap_next  = 1'b0;
                    prod_next  = FW'(1);
                    k_next     = '0;
                    limit_next = '0;
                    unique case (cmd)
                        mrc_pkg::CMD_LOAD:
                        begin
                            limit_next = n_dims;
                            state_next = mrc_pkg::S_PROD;
                        end
                        mrc_pkg::CMD_SET_INDEX,
                        mrc_pkg::CMD_STEP_ONE:
                        begin
                            limit_next = sel_in_ok ? CW'(dim_select) : '0;
                            state_next = mrc_pkg::S_PROD;
                        end
                        default:
                        begin
                            state_next = mrc_pkg::S_UPDATE;
                        end
                    endcase
                end
            end

            mrc_pkg::S_PROD:
            begin
                // Build stride or total, one extent per cycle
                if (k_reg == limit_reg)
                begin
                    state_next = mrc_pkg::S_CHECK;
                end
                else
                begin
                    prod_next = mul_lo;
                    k_next    = k_inc;
                end
            end

            mrc_pkg::S_CHECK:
            begin
                state_next = mrc_pkg::S_FINISH;
                unique case (cmd_reg)
                    mrc_pkg::CMD_LOAD:
                    begin
                        if (fv_reg >= prod_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = fv_reg;
                            div_divisor  = ext[0];
                            k_next       = '0;
                            state_next   = mrc_pkg::S_DIV_WAIT;
                        end
                    end
                    mrc_pkg::CMD_SET_INDEX:
                    begin
                        if (!sel_ok || (val_reg >= ext_sel))
                            err_next = 1'b1;
                        else
                            state_next = mrc_pkg::S_MUL_OLD;
                    end
                    mrc_pkg::CMD_STEP_ONE:
                    begin
                        if (!sel_ok || (({1'b0, idx_sel} + 1'b1) >= {1'b0, ext_sel}))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            idx_next[sel_i] = idx_sel + 1'b1;
                            flat_next       = flat_reg + prod_reg;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b0;
                    end
                endcase
            end

            mrc_pkg::S_MUL_OLD:
            begin
                // Drop the old index's share of the flat position
                acc_next   = flat_reg - mul_lo;
                state_next = mrc_pkg::S_MUL_NEW;
            end

            mrc_pkg::S_MUL_NEW:
            begin
                flat_next       = acc_reg + mul_lo;
                idx_next[sel_i] = val_reg;
                state_next      = mrc_pkg::S_FINISH;
            end

            mrc_pkg::S_DIV_WAIT:
            begin
                // Remainder is this dimension's index, quotient goes on
                if (div_stat.done)
                begin
                    idx_next[k_i] = div_rem;
                    if (k_inc == n_dims)
                    begin
                        flat_next  = fv_reg;
                        state_next = mrc_pkg::S_FINISH;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        k_next    = k_inc;
                    end
                end
            end

            mrc_pkg::S_UPDATE:
            begin
                unique case (cmd_reg)
                    mrc_pkg::CMD_STEP_ALL:
                    begin
                        idx_next  = step_idx;
                        flat_next = step_carry ? '0 : flat_reg + 1'b1;
                        wrap_next = step_carry;
                    end
                    mrc_pkg::CMD_CLEAR:
                    begin
                        for (int d = 0; d < MAX_DIMS; d++)
                            idx_next[d] = '0;
                        flat_next = '0;
                    end
                    default:
                    begin
                        wrap_next = 1'b0;
                    end
                endcase
                state_next = mrc_pkg::S_FINISH;
            end

            mrc_pkg::S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_flat_next = flat_reg;
                    for (int d = 0; d < NO; d++)
                    begin
                        if ((d < MAX_DIMS) && (CW'(d) < n_dims))
                            out_idx_next[d] = idx_reg[IW'(d)];
                        else
                            out_idx_next[d] = '0;
                    end
                    out_err_next   = err_reg;
                    out_wrap_next  = wrap_reg;
                    out_valid_next = 1'b1;
                    state_next     = mrc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrc_pkg::S_IDLE;
            num_dims_reg  <= mrc_pkg::NUM_W'(1);
            flat_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                size_reg[d] <= SW'(1);
                idx_reg[d]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            num_dims_reg  <= num_dims_next;
            flat_reg      <= flat_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        fv_reg       <= fv_next;
        sel_reg      <= sel_next;
        val_reg      <= val_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        k_reg        <= k_next;
        limit_reg    <= limit_next;
        err_reg      <= err_next;
        wrap_reg     <= wrap_next;
        out_flat_reg <= out_flat_next;
        out_idx_reg  <= out_idx_next;
        out_err_reg  <= out_err_next;
        out_wrap_reg <= out_wrap_next;
    end

    assign in_stall    = (state_reg != mrc_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign flat_pos    = out_flat_reg;
    assign idx0        = out_idx_reg[0];
    assign idx1        = out_idx_reg[1];
    assign idx2        = out_idx_reg[2];
    assign idx3        = out_idx_reg[3];
    assign idx4        = out_idx_reg[4];
    assign idx5        = out_idx_reg[5];
    assign range_error = out_err_reg;
    assign wrapped     = out_wrap_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != mrc_pkg::S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == mrc_pkg::S_DIV_WAIT))
        else $error("divider active outside the load sequence");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(range_error && wrapped))
        else $error("range error and wrap flagged together");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrc_pkg::S_IDLE) |-> idx_ok)
        else $error("stored index at or above its extent");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the mixed-radix index counter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int DIMS          = mrc_pkg::DEF_MAX_DIMS;
    localparam int SIZE_W        = mrc_pkg::DEF_SIZE_WIDTH;
    localparam int FLAT_W        = mrc_pkg::FLAT_W;
    localparam int CMD_W         = mrc_pkg::CMD_W;
    localparam int SEL_W         = mrc_pkg::SEL_W;
    localparam int NUM_W         = mrc_pkg::NUM_W;
    localparam int REG_IDX_W     = mrc_pkg::REG_IDX_W;
    localparam int OUT_IDX       = mrc_pkg::OUT_IDX;
    localparam int CFG_W         = (SIZE_W > NUM_W) ? SIZE_W : NUM_W;
    localparam int REG_UNUSED    = (1 << REG_IDX_W) - 1;
    localparam int CMD_CODE_MAX  = (1 << CMD_W) - 1;
    localparam int SEL_MAX       = (1 << SEL_W) - 1;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int IDLE_GAP      = 16;    // cycles of quiet before a register write
    localparam int END_GAP       = 64;    // cycles of quiet before the verdict
    localparam int PRESSURE_AT   = 200;   // results seen before the long hold-off
    localparam int PRESSURE_LEN  = 300;

    // One result item: flat position, every index and both flags.
    typedef struct packed {
        logic [FLAT_W-1:0]              flat;
        logic [OUT_IDX-1:0][SIZE_W-1:0] idx;
        logic                           range_err;
        logic                           wrap;
    } counter_view_t;

    typedef int unsigned size_list_t [DIMS];

    // Tracks the counter as the block should see it and matches its results.
    class counter_scoreboard;
        logic [NUM_W-1:0]   dims_reg;
        logic [SIZE_W-1:0]  size_reg  [DIMS];
        logic [SIZE_W-1:0]  index_now [DIMS];
        logic [FLAT_W-1:0]  flat_now;
        logic [FLAT_W-1:0]  total_now;
        counter_view_t      expected_q [$];
        int                 mismatches;
        int                 checked;
        int                 commands;
        int                 rejects;
        int                 wraps;

        function new();
            dims_reg = NUM_W'(1);
            foreach (size_reg[d]) size_reg[d] = SIZE_W'(1);
            mismatches = 0;
            checked    = 0;
            commands   = 0;
            rejects    = 0;
            wraps      = 0;
            rebuild();
        endfunction

        function int unsigned dims_in_use();
            if (dims_reg == 0) return 1;
            if (dims_reg > DIMS) return DIMS;
            return 32'(dims_reg);
        endfunction

        function int unsigned extent_of(int unsigned d);
            return (size_reg[d] == 0) ? 1 : 32'(size_reg[d]);
        endfunction

        // Product of the extents below dimension d.
        function logic [63:0] stride_of(int unsigned d);
            logic [63:0] p;
            p = 64'd1;
            for (int unsigned k = 0; k < d; k++)
                p = (p * 64'(extent_of(k))) & 64'({FLAT_W{1'b1}});
            return p;
        endfunction

        function void clear_position();
            foreach (index_now[d]) index_now[d] = '0;
            flat_now = '0;
        endfunction

        function void rebuild();
            total_now = FLAT_W'(stride_of(dims_in_use()));
            clear_position();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(int unsigned sel, logic [CFG_W-1:0] data);
            if (sel == mrc_pkg::REG_NUM_DIMS)
                dims_reg = data[NUM_W-1:0];
            else if (sel >= mrc_pkg::REG_SIZE_DIM0 && sel < mrc_pkg::REG_SIZE_DIM0 + DIMS)
                size_reg[sel - mrc_pkg::REG_SIZE_DIM0] = data[SIZE_W-1:0];
            else
                return;
            rebuild();
        endfunction

        // Apply one accepted command and queue the result it must produce.
        function void note_command(logic [CMD_W-1:0] c, logic [FLAT_W-1:0] fv,
                                   logic [SEL_W-1:0] sel, logic [SIZE_W-1:0] val);
            int unsigned   n;
            logic [63:0]   st;
            logic [63:0]   rest;
            logic [63:0]   sum;
            bit            carry;
            counter_view_t r;
            n = dims_in_use();
            r = '0;
            case (c)
                mrc_pkg::CMD_STEP_ALL:
                begin
                    carry = 1;
                    for (int unsigned d = 0; d < n && carry; d++)
                    begin
                        if (int'(index_now[d]) + 1 < extent_of(d))
                        begin
                            index_now[d] = index_now[d] + 1'b1;
                            carry = 0;
                        end
                        else
                        begin
                            index_now[d] = '0;
                        end
                    end
                    if (carry)
                    begin
                        r.wrap   = 1'b1;
                        flat_now = '0;
                    end
                    else
                    begin
                        flat_now = flat_now + 1'b1;
                    end
                end
                mrc_pkg::CMD_CLEAR: clear_position();
                mrc_pkg::CMD_LOAD:
                begin
                    if (fv >= total_now)
                    begin
                        r.range_err = 1'b1;
                    end
                    else
                    begin
                        rest = 64'(fv);
                        for (int unsigned d = 0; d < n; d++)
                        begin
                            index_now[d] = SIZE_W'(rest % 64'(extent_of(d)));
                            rest = rest / 64'(extent_of(d));
                        end
                        flat_now = fv;
                    end
                end
                mrc_pkg::CMD_SET_INDEX:
                begin
                    if (sel >= n)
                    begin
                        r.range_err = 1'b1;
                    end
                    else if (val >= extent_of(sel))
                    begin
                        r.range_err = 1'b1;
                    end
                    else
                    begin
                        st  = stride_of(sel);
                        sum = {16'b0, flat_now} - st * 64'(index_now[sel]) + st * 64'(val);
                        flat_now = sum[FLAT_W-1:0];
                        index_now[sel] = val;
                    end
                end
                mrc_pkg::CMD_STEP_ONE:
                begin
                    if (sel >= n)
                    begin
                        r.range_err = 1'b1;
                    end
                    else if (int'(index_now[sel]) + 1 >= extent_of(sel))
                    begin
                        r.range_err = 1'b1;
                    end
                    else
                    begin
                        index_now[sel] = index_now[sel] + 1'b1;
                        sum = {16'b0, flat_now} + stride_of(sel);
                        flat_now = sum[FLAT_W-1:0];
                    end
                end
                default: ;  // unused codes leave everything alone
            endcase
            r.flat = flat_now;
            for (int unsigned d = 0; d < OUT_IDX; d++)
                r.idx[d] = (d < n) ? index_now[d] : '0;
            commands++;
            if (r.range_err) rejects++;
            if (r.wrap) wraps++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string what, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, seen);
            end
        endfunction

        function void check_result(counter_view_t got);
            counter_view_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual flat %0h",
                         $time, got.flat);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("flat_pos", 64'(want.flat), 64'(got.flat));
            for (int d = 0; d < OUT_IDX; d++)
                compare_field($sformatf("idx%0d", d), 64'(want.idx[d]), 64'(got.idx[d]));
            compare_field("range_error", 64'(want.range_err), 64'(got.range_err));
            compare_field("wrapped", 64'(want.wrap), 64'(got.wrap));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [FLAT_W-1:0]    flat_value;
    logic [SEL_W-1:0]     dim_select;
    logic [SIZE_W-1:0]    index_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [FLAT_W-1:0]    flat_pos;
    logic [SIZE_W-1:0]    idx0;
    logic [SIZE_W-1:0]    idx1;
    logic [SIZE_W-1:0]    idx2;
    logic [SIZE_W-1:0]    idx3;
    logic [SIZE_W-1:0]    idx4;
    logic [SIZE_W-1:0]    idx5;
    logic                 range_error;
    logic                 wrapped;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    counter_scoreboard sb = new();

    mixed_radix_index_counter DUT (.*);

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Sample both channels at the edge: note each accepted command, check each
    // accepted result against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        counter_view_t got;
        if (rst_n && in_valid && !in_stall)
            sb.note_command(cmd, flat_value, dim_select, index_value);
        if (rst_n && out_valid && !out_stall)
        begin
            got.flat      = flat_pos;
            got.idx       = {idx5, idx4, idx3, idx2, idx1, idx0};
            got.range_err = range_error;
            got.wrap      = wrapped;
            sb.check_result(got);
        end
    end

    // Result side: stall at the current rate, and once hold off for a long
    // stretch so the block fills up and pushes back on its input.
    initial
    begin : receiver
        int unsigned hold_left;
        bit          held_once;
        out_stall = 1'b0;
        hold_left = 0;
        held_once = 0;
        forever
        begin
            @(posedge clk);
            if (!held_once && sb.checked >= PRESSURE_AT)
            begin
                held_once = 1;
                hold_left = PRESSURE_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one item, with random idle cycles first; return at the accepting
    // edge with valid still high so back-to-back items need no extra cycle.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [FLAT_W-1:0] fv,
                             input logic [SEL_W-1:0] sel, input logic [SIZE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        flat_value  <= fv;
        dim_select  <= sel;
        index_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Program the dimension count and all six extents, one write per cycle.
    task automatic configure(input logic [NUM_W-1:0] dims, input size_list_t sizes);
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom);
        data[NUM_W-1:0] = dims;     // keep junk in the upper bits
        cfg_we    <= 1'b1;
        cfg_index <= REG_IDX_W'(mrc_pkg::REG_NUM_DIMS);
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_register(mrc_pkg::REG_NUM_DIMS, data);
        for (int d = 0; d < DIMS; d++)
        begin
            cfg_index <= REG_IDX_W'(mrc_pkg::REG_SIZE_DIM0 + d);
            cfg_wdata <= CFG_W'(sizes[d]);
            @(posedge clk);
            sb.write_register(mrc_pkg::REG_SIZE_DIM0 + d, CFG_W'(sizes[d]));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly legal commands aimed at the counter's current shape, with
    // a share of rejected and unused ones mixed in.
    task automatic send_random();
        logic [CMD_W-1:0]  c;
        logic [FLAT_W-1:0] fv;
        logic [SEL_W-1:0]  sel;
        logic [SIZE_W-1:0] val;
        logic [63:0]       wide;
        logic [63:0]       near;
        int unsigned       n;
        int unsigned       pick;
        n    = sb.dims_in_use();
        pick = $urandom_range(99);
        wide = {$urandom, $urandom};
        fv   = wide[FLAT_W-1:0];
        sel  = ($urandom_range(99) < 85) ? SEL_W'($urandom_range(n - 1))
                                         : SEL_W'($urandom_range(SEL_MAX));
        val  = SIZE_W'($urandom);
        if (pick < 35)
        begin
            c = mrc_pkg::CMD_STEP_ALL;
        end
        else if (pick < 40)
        begin
            c = mrc_pkg::CMD_CLEAR;
        end
        else if (pick < 60)
        begin
            c = mrc_pkg::CMD_LOAD;
            near = (sb.total_now < 16) ? 64'(sb.total_now) : 64'd16;
            case ($urandom_range(9))
                0:       ;  // full-width value, almost always rejected
                1:       fv = sb.total_now - 1'b1 + FLAT_W'($urandom_range(1));
                2, 3, 4: fv = FLAT_W'(64'(sb.total_now) - 64'd1 - (wide % near));
                default: fv = FLAT_W'(wide % 64'(sb.total_now));
            endcase
        end
        else if (pick < 77)
        begin
            c = mrc_pkg::CMD_SET_INDEX;
            if (sel < n)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    val = SIZE_W'(sb.extent_of(sel) - 1);
                else if (pick < 85)
                    val = SIZE_W'($urandom_range(sb.extent_of(sel) - 1));
            end
        end
        else if (pick < 95)
        begin
            c = mrc_pkg::CMD_STEP_ONE;
        end
        else
        begin
            c = CMD_W'(CMD_CODE_MAX
                       - $urandom_range(CMD_CODE_MAX - int'(mrc_pkg::CMD_STEP_ONE) - 1));
        end
        send_item(c, fv, sel, val);
    endtask

    initial
    begin : stimulus
        size_list_t sizes;

        // Hold every input at a known value during reset.
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        cmd            = mrc_pkg::CMD_CLEAR;
        flat_value     = '0;
        dim_select     = '0;
        index_value    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset shape is one dimension of extent one, so a full
        // step wraps at once and a step of one index is out of range.
        send_item(mrc_pkg::CMD_STEP_ALL,  '0, '0, '0);
        send_item(mrc_pkg::CMD_LOAD,      '0, '0, '0);
        send_item(mrc_pkg::CMD_LOAD,      '1, '0, '0);
        send_item(mrc_pkg::CMD_SET_INDEX, '0, '0, '0);
        send_item(mrc_pkg::CMD_STEP_ONE,  '0, '0, '0);
        send_item(mrc_pkg::CMD_SET_INDEX, '1, '1, '1);
        for (int c = int'(mrc_pkg::CMD_STEP_ONE) + 1; c <= CMD_CODE_MAX; c++)
            send_item(CMD_W'(c), '1, '1, '1);
        drain();

        // Directed: three dimensions 2 x 3 x 4, a zero extent beyond them.
        sizes = '{2, 3, 4, 0, 1, 1};
        configure(3'd3, sizes);
        send_item(mrc_pkg::CMD_STEP_ALL,  '0, '0, '0);
        send_item(mrc_pkg::CMD_LOAD,      48'd23, '0, '0);   // last position
        send_item(mrc_pkg::CMD_STEP_ALL,  '0, '0, '0);       // carries out of the top
        send_item(mrc_pkg::CMD_LOAD,      48'd24, '0, '0);   // one past the total
        send_item(mrc_pkg::CMD_LOAD,      '1, '0, '0);
        send_item(mrc_pkg::CMD_LOAD,      48'd5, '0, '0);
        send_item(mrc_pkg::CMD_SET_INDEX, '0, 3'd2, 8'd3);
        send_item(mrc_pkg::CMD_SET_INDEX, '0, 3'd2, 8'd4);   // index beyond extent
        send_item(mrc_pkg::CMD_SET_INDEX, '0, 3'd3, 8'd0);   // dimension not in use
        send_item(mrc_pkg::CMD_CLEAR,     '0, '0, '0);
        send_item(mrc_pkg::CMD_STEP_ONE,  '0, 3'd0, '0);
        send_item(mrc_pkg::CMD_STEP_ONE,  '0, 3'd0, '0);     // would run past the end
        send_item(mrc_pkg::CMD_STEP_ONE,  '0, 3'd2, '0);
        send_item(mrc_pkg::CMD_STEP_ONE,  '0, 3'd5, '0);
        send_item(mrc_pkg::CMD_SET_INDEX, '0, 3'd1, 8'd2);
        send_item(mrc_pkg::CMD_STEP_ALL,  '0, '0, '0);
        drain();

        // Random phases over several shapes, extremes among them.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct  = 12;
                recv_stall_pct = 77;
            end
            else if (ph < 6)
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 12;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            foreach (sizes[d]) sizes[d] = $urandom_range(255);
            case (ph)
                0:
                begin
                    sizes[0] = 3;
                    sizes[1] = 5;
                    configure(3'd2, sizes);
                end
                1:
                begin
                    foreach (sizes[d]) sizes[d] = 2;    // wraps come often
                    configure(3'd6, sizes);
                end
                2:
                begin
                    foreach (sizes[d]) sizes[d] = 255;  // largest total
                    configure(3'd6, sizes);
                end
                3:
                begin
                    sizes[0] = 255;
                    configure(3'd0, sizes);             // count zero acts as one
                end
                4:
                begin
                    sizes = '{0, 3, 0, 2, 255, 1};
                    configure(3'd7, sizes);             // count above the maximum
                end
                5:
                begin
                    foreach (sizes[d]) sizes[d] = $urandom_range(1, 255);
                    configure(3'd4, sizes);
                end
                6:
                begin
                    foreach (sizes[d]) sizes[d] = $urandom_range(1, 8);
                    configure(3'd5, sizes);
                end
                default:
                begin
                    sizes[0] = 1;
                    configure(3'd1, sizes);
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halfway through one phase, poke the unused register index:
                // the position must survive it.
                if (ph == 4 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                    cfg_we    <= 1'b1;
                    cfg_index <= REG_IDX_W'(REG_UNUSED);
                    cfg_wdata <= CFG_W'($urandom);
                    @(posedge clk);
                    sb.write_register(REG_UNUSED, cfg_wdata);
                    cfg_we <= 1'b0;
                end
                send_random();
            end
            drain();
        end

        repeat (END_GAP) @(posedge clk);
        $display("Ran %0d commands over %0d counter shapes, one to six dimensions,",
                 sb.commands, PHASES + 2);
        $display("extents 0 to 255; checked %0d results: %0d rejected, %0d full wraps, %0d mismatches.",
                 sb.checked, sb.rejects, sb.wraps, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
